### hdl/assert_macros.svh
// assertion macros shared by the sanitizer modules
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### hdl/aps_pkg.sv
// types and constants of the archive path sanitizer
// used by every module of the block; no dependencies
package aps_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_UTF8 = 3'd1;
  localparam logic [2:0] ST_ABSOLUTE = 3'd2;
  localparam logic [2:0] ST_UNSAFE   = 3'd3;
  localparam logic [2:0] ST_TRAILING = 3'd4;
  localparam logic [2:0] ST_CONTROL  = 3'd5;

  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam logic [20:0] CP_MIN2   = 21'h00080;
  localparam logic [20:0] CP_MIN3   = 21'h00800;
  localparam logic [20:0] CP_MIN4   = 21'h10000;
  localparam logic [20:0] CP_MAX    = 21'h10ffff;
  localparam logic [20:0] CP_SUR_LO = 21'h0d800;
  localparam logic [20:0] CP_SUR_HI = 21'h0dfff;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       key_byte_valid;
    logic       end_of_path;
    logic [2:0] status;
    logic       is_directory;
  } aps_word_t;

  // one queue entry per non-slash byte and per final byte: optional separator word ahead of the main word
  typedef struct packed {
    logic      sep;
    aps_word_t main;
  } aps_entry_t;

endpackage

### hdl/aps_front.sv
// front end: takes path bytes, tracks utf-8 and component state, builds entries
// depends on aps_pkg and assert_macros.svh
`include "assert_macros.svh"
module aps_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_path_byte,
  input  logic               in_final_byte,
  output logic               q_push,
  output aps_pkg::aps_entry_t q_wdata,
  input  logic               q_full
);

  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  ulen_r, ulen_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic        bad_r, bad_nxt;
  logic        start_r;
  logic        abs_r, abs_nxt;
  logic        unsafe_r, unsafe_nxt;
  logic [1:0]  clen_r, clen_nxt;
  logic        dots_r, dots_nxt;
  logic        ctrl_r, ctrl_nxt;
  logic        trail_r, trail_nxt;
  logic [2:0]  fke_r, fke_nxt;
  logic        knon_r, knon_nxt;
  logic        sep_r, sep_nxt;

  logic        accept, slash, fin;
  logic [7:0]  b, kb;
  logic [20:0] cp_shift;
  logic [1:0]  clen_u;
  logic        dots_u, ctrl_u, trail_u;
  logic [1:0]  cl_len;
  logic        cl_do, cl_allow, cl_dots, cl_ctrl, cl_trail;
  logic [2:0]  verdict;

  assign b        = in_path_byte;
  assign fin      = in_final_byte;
  assign in_full  = q_full;
  assign accept   = in_push && !q_full;
  assign slash    = (b == aps_pkg::CH_SLASH) || (b == aps_pkg::CH_BSLASH);
  assign cp_shift = {cp_r[14:0], b[5:0]};

  // utf-8 decoder
  always_comb begin
    pend_nxt = pend_r;
    ulen_nxt = ulen_r;
    cp_nxt   = cp_r;
    bad_nxt  = bad_r;
    if (pend_r != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        bad_nxt  = 1'b1;
        pend_nxt = 2'd0;
      end else begin
        cp_nxt   = cp_shift;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          if ((ulen_r == 2'd1 && cp_shift < aps_pkg::CP_MIN2) ||
              (ulen_r == 2'd2 && cp_shift < aps_pkg::CP_MIN3) ||
              (ulen_r == 2'd3 && cp_shift < aps_pkg::CP_MIN4) ||
              (cp_shift > aps_pkg::CP_MAX) ||
              (cp_shift >= aps_pkg::CP_SUR_LO && cp_shift <= aps_pkg::CP_SUR_HI)) begin
            bad_nxt = 1'b1;
          end
        end
      end
    end else if (!b[7]) begin
      if (b == 8'd0) begin
        bad_nxt = 1'b1;
      end
    end else if (b[7:5] == 3'b110) begin
      ulen_nxt = 2'd1;
      pend_nxt = 2'd1;
      cp_nxt   = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      ulen_nxt = 2'd2;
      pend_nxt = 2'd2;
      cp_nxt   = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      ulen_nxt = 2'd3;
      pend_nxt = 2'd3;
      cp_nxt   = {18'd0, b[2:0]};
    end else begin
      bad_nxt = 1'b1;
    end
    if (fin && pend_nxt != 2'd0) begin
      bad_nxt = 1'b1;
    end
  end

  // component tracking and closing
  always_comb begin
    clen_u  = (clen_r == 2'd3) ? clen_r : clen_r + 2'd1;
    dots_u  = dots_r && (b == aps_pkg::CH_DOT);
    ctrl_u  = ctrl_r || (b < aps_pkg::CH_SPACE) || (b == aps_pkg::CH_DEL);
    trail_u = (b == aps_pkg::CH_SPACE) || (b == aps_pkg::CH_DOT);

    abs_nxt = abs_r || (start_r && slash) || (b == aps_pkg::CH_COLON);

    cl_do    = slash || fin;
    cl_allow = fin;
    cl_len   = slash ? clen_r  : clen_u;
    cl_dots  = slash ? dots_r  : dots_u;
    cl_ctrl  = slash ? ctrl_r  : ctrl_u;
    cl_trail = slash ? trail_r : trail_u;

    unsafe_nxt = unsafe_r;
    fke_nxt    = fke_r;
    if (cl_do) begin
      if (cl_len == 2'd0) begin
        if (!cl_allow) begin
          unsafe_nxt = 1'b1;
        end
      end else begin
        if (cl_dots && cl_len <= 2'd2) begin
          unsafe_nxt = 1'b1;
        end
        if (fke_r == aps_pkg::ST_OK) begin
          if (cl_trail) begin
            fke_nxt = aps_pkg::ST_TRAILING;
          end else if (cl_ctrl) begin
            fke_nxt = aps_pkg::ST_CONTROL;
          end
        end
      end
    end

    if (cl_do) begin
      clen_nxt  = 2'd0;
      dots_nxt  = 1'b1;
      ctrl_nxt  = 1'b0;
      trail_nxt = 1'b0;
    end else begin
      clen_nxt  = clen_u;
      dots_nxt  = dots_u;
      ctrl_nxt  = ctrl_u;
      trail_nxt = trail_u;
    end

    knon_nxt = knon_r || !slash;
    sep_nxt  = slash ? (sep_r || knon_r) : 1'b0;

    if (bad_nxt) begin
      verdict = aps_pkg::ST_BAD_UTF8;
    end else if (abs_nxt) begin
      verdict = aps_pkg::ST_ABSOLUTE;
    end else if (unsafe_nxt) begin
      verdict = aps_pkg::ST_UNSAFE;
    end else begin
      verdict = fke_nxt;
    end

    kb = (b >= aps_pkg::CH_UPPER_A && b <= aps_pkg::CH_UPPER_Z) ? (b | aps_pkg::CASE_BIT) : b;
  end

  // entry to the queue
  always_comb begin
    q_push                       = accept && (!slash || fin);
    q_wdata.sep                  = !slash && sep_r;
    q_wdata.main.key_byte        = slash ? 8'd0 : kb;
    q_wdata.main.key_byte_valid  = !slash;
    q_wdata.main.end_of_path     = fin;
    q_wdata.main.status          = fin ? verdict : aps_pkg::ST_OK;
    q_wdata.main.is_directory    = fin && slash;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && fin)) begin
      pend_r   <= 2'd0;
      ulen_r   <= 2'd0;
      cp_r     <= 21'd0;
      bad_r    <= 1'b0;
      start_r  <= 1'b1;
      abs_r    <= 1'b0;
      unsafe_r <= 1'b0;
      clen_r   <= 2'd0;
      dots_r   <= 1'b1;
      ctrl_r   <= 1'b0;
      trail_r  <= 1'b0;
      fke_r    <= aps_pkg::ST_OK;
      knon_r   <= 1'b0;
      sep_r    <= 1'b0;
    end else if (accept) begin
      pend_r   <= pend_nxt;
      ulen_r   <= ulen_nxt;
      cp_r     <= cp_nxt;
      bad_r    <= bad_nxt;
      start_r  <= 1'b0;
      abs_r    <= abs_nxt;
      unsafe_r <= unsafe_nxt;
      clen_r   <= clen_nxt;
      dots_r   <= dots_nxt;
      ctrl_r   <= ctrl_nxt;
      trail_r  <= trail_nxt;
      fke_r    <= fke_nxt;
      knon_r   <= knon_nxt;
      sep_r    <= sep_nxt;
    end
  end

  `ASSERT_IMPLY(a_sep_needs_key, clk, rst_n, sep_r, knon_r, "separator armed with empty key")
  `ASSERT_NEXT(a_fin_restarts, clk, rst_n, accept && fin, start_r && !sep_r && !knon_r, "path state not cleared after final word")
  `ASSERT_IMPLY(a_fke_code, clk, rst_n, fke_r != aps_pkg::ST_OK, fke_r == aps_pkg::ST_TRAILING || fke_r == aps_pkg::ST_CONTROL, "bad key error code")

endmodule

### hdl/aps_fifo.sv
// small register queue between the front end and the back end
// depends on aps_pkg and assert_macros.svh
`include "assert_macros.svh"
module aps_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  aps_pkg::aps_entry_t wdata,
  output logic                full,
  input  logic                pop,
  output aps_pkg::aps_entry_t rdata,
  output logic                empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  aps_pkg::aps_entry_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_nxt;
      end
      if (do_pop) begin
        rp_r <= rp_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= CW'(DEPTH), "queue count out of range")

endmodule

### hdl/aps_back.sv
// back end: splits queue entries into result words and holds the output register
// depends on aps_pkg and assert_macros.svh
`include "assert_macros.svh"
module aps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  aps_pkg::aps_entry_t q_rdata,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output aps_pkg::aps_word_t  out_word
);

  aps_pkg::aps_word_t out_r, out_nxt;
  logic               vld_r;
  logic               phase_r, phase_nxt;
  logic               load, emit_sep;

  assign load      = !q_empty && (!vld_r || out_pop);
  assign emit_sep  = q_rdata.sep && !phase_r;
  assign q_pop     = load && !emit_sep;
  assign out_empty = !vld_r;
  assign out_word  = out_r;

  always_comb begin
    if (emit_sep) begin
      out_nxt.key_byte       = aps_pkg::CH_SLASH;
      out_nxt.key_byte_valid = 1'b1;
      out_nxt.end_of_path    = 1'b0;
      out_nxt.status         = aps_pkg::ST_OK;
      out_nxt.is_directory   = 1'b0;
      phase_nxt              = 1'b1;
    end else begin
      out_nxt   = q_rdata.main;
      phase_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (load) begin
        vld_r   <= 1'b1;
        phase_r <= phase_nxt;
      end else if (out_pop) begin
        vld_r <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLY(a_phase_head, clk, rst_n, phase_r, !q_empty && q_rdata.sep, "separator phase without separator entry")

endmodule

### hdl/archive_path_sanitizer_unit.sv
// top level of the archive path sanitizer: front end, entry queue, back end
// depends on aps_pkg, aps_front, aps_fifo, aps_back
//
// channel  dir  handshake          payload
// in_      in   in_push / in_full  in_path_byte, in_final_byte
// out_     out  out_pop / out_empty out_key_byte, out_key_byte_valid, out_end_of_path,
//                                  out_status, out_is_directory
//
// one path byte accepted per cycle while the entry queue has room
// a byte that opens a new component after a slash that follows key bytes gives two words,
// a separator and then its own; otherwise one word per cycle leaves the output register
// while out_pop takes them; a byte's first word is registered in the queue, then in the output register
// rst_n clears the path state, the queue and the valid flag of the output register
module archive_path_sanitizer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_path_byte,
  input  logic       in_final_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_key_byte,
  output logic       out_key_byte_valid,
  output logic       out_end_of_path,
  output logic [2:0] out_status,
  output logic       out_is_directory
);

  aps_pkg::aps_entry_t q_wdata, q_rdata;
  aps_pkg::aps_word_t  out_word;
  logic                q_push, q_full, q_pop, q_empty;

  aps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_path_byte  (in_path_byte),
    .in_final_byte (in_final_byte),
    .q_push        (q_push),
    .q_wdata       (q_wdata),
    .q_full        (q_full)
  );

  aps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  aps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  assign out_key_byte       = out_word.key_byte;
  assign out_key_byte_valid = out_word.key_byte_valid;
  assign out_end_of_path    = out_word.end_of_path;
  assign out_status         = out_word.status;
  assign out_is_directory   = out_word.is_directory;

endmodule

### tb/archive_path_sanitizer_unit_test.sv
// self-checking testbench for archive_path_sanitizer_unit: queue-style push/pop stimulus,
// a byte-level path checker predicting every key word, random stalls on both sides
// depends on aps_pkg and archive_path_sanitizer_unit
`timescale 1ns / 100ps

module archive_path_sanitizer_unit_test;

  localparam int RANDOM_BYTES = 600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       drain;
  } path_byte_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_path_byte = 8'h00;
  logic       in_final_byte = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_key_byte;
  logic       out_key_byte_valid;
  logic       out_end_of_path;
  logic [2:0] out_status;
  logic       out_is_directory;

  archive_path_sanitizer_unit dut (.*);

  path_byte_t         path_bytes_to_send[$];
  logic [7:0]         path_buf[$];
  aps_pkg::aps_word_t key_words_due[$];
  path_byte_t         next_byte;
  aps_pkg::aps_word_t seen_word;
  aps_pkg::aps_word_t due_word;
  int                 send_wait = 0;
  int                 take_wait = 0;
  bit                 send_steady = 1'b0;
  bit                 take_steady = 1'b0;
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;

  // path checker state
  logic [1:0]  u8_left;
  logic [1:0]  u8_len;
  logic [20:0] cp_acc;
  logic        u8_err;
  logic        first_byte;
  logic        abs_flag;
  logic        unsafe_flag;
  logic        last_slash;
  logic [1:0]  comp_len;
  logic        comp_dots;
  logic        comp_ctrl;
  logic        comp_tail;
  logic [2:0]  key_err;
  logic        key_started;
  logic        sep_armed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic aps_pkg::aps_word_t key_word(logic [7:0] kb, logic kv, logic eop,
                                                  logic [2:0] st, logic dir);
    aps_pkg::aps_word_t w;
    w.key_byte = kb;
    w.key_byte_valid = kv;
    w.end_of_path = eop;
    w.status = st;
    w.is_directory = dir;
    return w;
  endfunction

  task automatic add_byte(logic [7:0] v);
    path_buf.insert(path_buf.size(), v);
  endtask

  task automatic add_due(aps_pkg::aps_word_t w);
    key_words_due.insert(key_words_due.size(), w);
  endtask

  task automatic reset_path();
    u8_left = '0;
    u8_len = '0;
    cp_acc = '0;
    u8_err = 1'b0;
    first_byte = 1'b1;
    abs_flag = 1'b0;
    unsafe_flag = 1'b0;
    last_slash = 1'b0;
    comp_len = '0;
    comp_dots = 1'b1;
    comp_ctrl = 1'b0;
    comp_tail = 1'b0;
    key_err = aps_pkg::ST_OK;
    key_started = 1'b0;
    sep_armed = 1'b0;
  endtask

  task automatic close_comp(logic slash_is_last);
    if (comp_len == 0) begin
      if (!slash_is_last) unsafe_flag = 1'b1;
    end else begin
      if (comp_dots && comp_len <= 2) unsafe_flag = 1'b1;
      if (key_err == aps_pkg::ST_OK) begin
        if (comp_tail) key_err = aps_pkg::ST_TRAILING;
        else if (comp_ctrl) key_err = aps_pkg::ST_CONTROL;
      end
    end
    comp_len = '0;
    comp_dots = 1'b1;
    comp_ctrl = 1'b0;
    comp_tail = 1'b0;
  endtask

  task automatic sanitize_byte(logic [7:0] b, logic fin);
    logic       is_slash;
    logic [7:0] kb;
    logic [2:0] st;
    is_slash = (b == aps_pkg::CH_SLASH || b == aps_pkg::CH_BSLASH);
    kb = (b >= aps_pkg::CH_UPPER_A && b <= aps_pkg::CH_UPPER_Z) ?
         (b | aps_pkg::CASE_BIT) : b;

    // utf-8 decoder
    if (u8_left != 0) begin
      if (b[7:6] != 2'b10) begin
        u8_err = 1'b1;
        u8_left = '0;
      end else begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        u8_left = u8_left - 1'b1;
        if (u8_left == 0 && ((u8_len == 1 && cp_acc < aps_pkg::CP_MIN2) ||
                             (u8_len == 2 && cp_acc < aps_pkg::CP_MIN3) ||
                             (u8_len == 3 && cp_acc < aps_pkg::CP_MIN4) ||
                             cp_acc > aps_pkg::CP_MAX ||
                             (cp_acc >= aps_pkg::CP_SUR_LO &&
                              cp_acc <= aps_pkg::CP_SUR_HI)))
          u8_err = 1'b1;
      end
    end else if (b[7] == 1'b0) begin
      if (b == 8'h00) u8_err = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      u8_len = 2'd1;
      cp_acc = {16'b0, b[4:0]};
      u8_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      u8_len = 2'd2;
      cp_acc = {17'b0, b[3:0]};
      u8_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      u8_len = 2'd3;
      cp_acc = {18'b0, b[2:0]};
      u8_left = 2'd3;
    end else begin
      u8_err = 1'b1;
    end
    if (fin && u8_left != 0) u8_err = 1'b1;

    if ((first_byte && is_slash) || b == aps_pkg::CH_COLON) abs_flag = 1'b1;
    first_byte = 1'b0;

    if (is_slash) begin
      close_comp(fin);
      if (key_started) sep_armed = 1'b1;
      last_slash = 1'b1;
    end else begin
      if (sep_armed) begin
        add_due(key_word(aps_pkg::CH_SLASH, 1'b1, 1'b0, aps_pkg::ST_OK, 1'b0));
        sep_armed = 1'b0;
      end
      if (comp_len < 3) comp_len = comp_len + 1'b1;
      if (b != aps_pkg::CH_DOT) comp_dots = 1'b0;
      if (b < aps_pkg::CH_SPACE || b == aps_pkg::CH_DEL) comp_ctrl = 1'b1;
      comp_tail = (b == aps_pkg::CH_SPACE || b == aps_pkg::CH_DOT);
      key_started = 1'b1;
      last_slash = 1'b0;
      if (fin) close_comp(1'b1);
    end

    if (fin) begin
      if (u8_err) st = aps_pkg::ST_BAD_UTF8;
      else if (abs_flag) st = aps_pkg::ST_ABSOLUTE;
      else if (unsafe_flag) st = aps_pkg::ST_UNSAFE;
      else st = key_err;
      add_due(key_word(is_slash ? 8'h00 : kb, !is_slash, 1'b1, st, last_slash));
      reset_path();
    end else if (!is_slash) begin
      add_due(key_word(kb, 1'b1, 1'b0, aps_pkg::ST_OK, 1'b0));
    end
  endtask

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'(8'h61 + $urandom_range(0, 25));
    if (r < 70) return 8'(aps_pkg::CH_UPPER_A + $urandom_range(0, 25));
    if (r < 82) return 8'(8'h30 + $urandom_range(0, 9));
    if (r < 88) return $urandom_range(0, 1) ? 8'h2d : 8'h5f;
    if (r < 94) return aps_pkg::CH_DOT;
    return aps_pkg::CH_SPACE;
  endfunction

  // raw encoding of cp in len bytes, whether or not len is the shortest form
  task automatic add_utf8(logic [20:0] cp, int len);
    case (len)
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic build_random_path();
    int          parts;
    int          kind;
    int          len;
    logic [20:0] cp;
    logic [7:0]  sep;
    path_buf.delete();
    parts = $urandom_range(1, 4);
    sep = aps_pkg::CH_SLASH;
    if ($urandom_range(0, 19) == 0)
      add_byte($urandom_range(0, 1) ? aps_pkg::CH_SLASH : aps_pkg::CH_BSLASH);
    for (int p = 0; p < parts; p++) begin
      if (p != 0) begin
        sep = $urandom_range(0, 3) == 0 ? aps_pkg::CH_BSLASH : aps_pkg::CH_SLASH;
        add_byte(sep);
        if ($urandom_range(0, 24) == 0) add_byte(sep);
      end
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        repeat ($urandom_range(1, 5)) add_byte(name_char());
      end else if (kind < 14) begin
        repeat ($urandom_range(1, 3)) add_byte(aps_pkg::CH_DOT);
      end else if (kind < 16) begin
        add_byte(name_char());
        len = $urandom_range(2, 4);
        case (len)
          2: cp = 21'($urandom_range(21'h80, 21'h7ff));
          3: begin
            cp = 21'($urandom_range(21'h800, 21'hffff));
            if (cp >= aps_pkg::CP_SUR_LO && cp <= aps_pkg::CP_SUR_HI) cp = cp + 21'h800;
          end
          default: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
        endcase
        add_utf8(cp, len);
      end else if (kind == 16) begin
        add_byte(name_char());
        case ($urandom_range(0, 7))
          0: add_utf8(21'($urandom_range(0, 21'h7f)), 2);
          1: add_utf8(21'($urandom_range(0, 21'h7ff)), 3);
          2: add_utf8(21'($urandom_range(0, 21'hffff)), 4);
          3: add_utf8(21'($urandom_range(aps_pkg::CP_SUR_LO, aps_pkg::CP_SUR_HI)), 3);
          4: add_utf8(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
          5: add_byte(8'($urandom_range(8'h80, 8'hbf)));
          6: begin
            add_byte(8'($urandom_range(8'hc2, 8'hf4)));
            add_byte(name_char());
          end
          default: add_byte($urandom_range(0, 1) ? 8'h00 :
                            8'($urandom_range(8'hf8, 8'hff)));
        endcase
      end else if (kind == 17) begin
        add_byte(name_char());
        add_byte($urandom_range(0, 4) == 0 ? aps_pkg::CH_DEL :
                 8'($urandom_range(1, 31)));
      end else if (kind == 18) begin
        add_byte(name_char());
        add_byte(aps_pkg::CH_COLON);
      end else begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
      end
    end
    kind = $urandom_range(0, 99);
    if (kind < 15) add_byte(sep);
    else if (kind < 20) add_byte(8'($urandom_range(8'hc2, 8'hf4)));
  endtask

  task automatic queue_path(bit drain);
    path_byte_t pb;
    foreach (path_buf[i]) begin
      pb.value = path_buf[i];
      pb.last = (i == path_buf.size() - 1);
      pb.drain = drain && (i == 0);
      path_bytes_to_send.insert(path_bytes_to_send.size(), pb);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) sanitize_byte(in_path_byte, in_final_byte);
      if (!(in_push && in_full)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_push <= 1'b0;
        end else if (path_bytes_to_send.size() == 0 ||
                     (path_bytes_to_send[0].drain && key_words_due.size() != 0)) begin
          in_push <= 1'b0;
        end else begin
          next_byte = path_bytes_to_send.pop_front();
          in_path_byte <= next_byte.value;
          in_final_byte <= next_byte.last;
          in_push <= 1'b1;
          if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
          send_wait = pick_gap(send_steady);
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        seen_word = key_word(out_key_byte, out_key_byte_valid, out_end_of_path, out_status,
                             out_is_directory);
        if (key_words_due.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: unexpected word key %h valid %b end %b status %0d dir %b",
                     $realtime, seen_word.key_byte, seen_word.key_byte_valid,
                     seen_word.end_of_path, seen_word.status, seen_word.is_directory);
          mismatch_count++;
        end else begin
          due_word = key_words_due.pop_front();
          if (seen_word.key_byte !== due_word.key_byte ||
              seen_word.key_byte_valid !== due_word.key_byte_valid ||
              seen_word.end_of_path !== due_word.end_of_path ||
              seen_word.status !== due_word.status ||
              seen_word.is_directory !== due_word.is_directory) begin
            if (mismatch_count < MAX_REPORTS)
              $display("%0t: mismatch exp %h %b %b %0d %b got %h %b %b %0d %b",
                       $realtime, due_word.key_byte, due_word.key_byte_valid,
                       due_word.end_of_path, due_word.status, due_word.is_directory,
                       seen_word.key_byte, seen_word.key_byte_valid,
                       seen_word.end_of_path, seen_word.status, seen_word.is_directory);
            mismatch_count++;
          end
        end
        if ($urandom_range(0, 29) == 0) take_steady = !take_steady;
        take_wait = pick_gap(take_steady);
      end
      if (take_wait > 0) begin
        take_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("archive_path_sanitizer_unit_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int random_start;
    int paths;
    reset_path();

    // upper-case bounds, separator and lower-casing
    path_buf = '{aps_pkg::CH_UPPER_A, aps_pkg::CH_UPPER_Z, aps_pkg::CH_SLASH, 8'h7a};
    queue_path(1'b0);
    // leading backslash
    path_buf = '{aps_pkg::CH_BSLASH, 8'h78};
    queue_path(1'b0);
    // colon, directory flag on a failing path
    path_buf = '{aps_pkg::CH_COLON, aps_pkg::CH_SLASH};
    queue_path(1'b1);
    path_buf = '{aps_pkg::CH_DOT, aps_pkg::CH_DOT};
    queue_path(1'b0);
    // empty component in the middle
    path_buf = '{8'h61, aps_pkg::CH_SLASH, aps_pkg::CH_SLASH, 8'h62};
    queue_path(1'b0);
    // second slash is the last byte
    path_buf = '{8'h64, aps_pkg::CH_SLASH, aps_pkg::CH_SLASH};
    queue_path(1'b0);
    path_buf = '{8'h61, aps_pkg::CH_SPACE};
    queue_path(1'b0);
    path_buf = '{aps_pkg::CH_DEL};
    queue_path(1'b0);
    path_buf = '{8'h00};
    queue_path(1'b0);
    // sequence still open at the end
    path_buf = '{8'hc3};
    queue_path(1'b0);
    path_buf = '{8'hff};
    queue_path(1'b0);
    path_buf = '{8'hc3, 8'ha9};
    queue_path(1'b0);

    random_start = path_bytes_to_send.size();
    paths = 0;
    while (path_bytes_to_send.size() - random_start < RANDOM_BYTES) begin
      build_random_path();
      queue_path(paths % 20 == 10);
      paths++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (path_bytes_to_send.size() != 0 || in_push || key_words_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("archive_path_sanitizer_unit_test: done, clean");
    end else begin
      $display("archive_path_sanitizer_unit_test: done, errors");
    end
    $finish;
  end

endmodule

### archive_path_sanitizer_unit.f
+incdir+hdl
hdl/aps_pkg.sv
hdl/aps_front.sv
hdl/aps_fifo.sv
hdl/aps_back.sv
hdl/archive_path_sanitizer_unit.sv
tb/archive_path_sanitizer_unit_test.sv
